// ===== rtl/core/mrmf_pkg.sv =====
// Shared types and codes for the Manhattan-radius max filter.
// Holds the beat structs, action and result codes, state enums and register indexes.
// Depends on nothing; the top and the pass engine import it, mrmf_ram uses no package.
package mrmf_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_RUN  = 2'd1,
        ACT_READ = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_RUN  = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_ROWS   = 2'd0,
        CFG_COLS   = 2'd1,
        CFG_RADIUS = 2'd2
    } cfg_index_t;

    localparam int CFG_DATA_BITS = 8;
    localparam int DIM_CFG_BITS  = 7;
    localparam int FIELD_PIX_BITS = 16;

    localparam logic [DIM_CFG_BITS-1:0]  ROWS_RESET   = 7'd64;
    localparam logic [DIM_CFG_BITS-1:0]  COLS_RESET   = 7'd64;
    localparam logic [CFG_DATA_BITS-1:0] RADIUS_RESET = 8'd1;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [15:0] pixel_in;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] pixel_out;
    } out_beat_t;

    typedef enum logic [2:0] {
        SLOT_CENTER = 3'd0,
        SLOT_LEFT   = 3'd1,
        SLOT_RIGHT  = 3'd2,
        SLOT_UP     = 3'd3,
        SLOT_DOWN   = 3'd4
    } slot_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_ISSUE,
        ENG_DRAIN,
        ENG_FINISH
    } eng_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN,
        ST_HOLD
    } top_state_t;

    typedef struct packed {
        logic pass_done;
        logic done;
    } eng_status_t;

endpackage

// ===== rtl/core/manhattan_radius_max_filter_top.sv =====
// Top level of the Manhattan-radius max filter (grayscale dilation with a diamond).
// Holds the handshakes, configuration registers, two image planes and the pass engine.
// Depends on mrmf_pkg, mrmf_ram and mrmf_pass_engine.
//
//   port group   direction  handshake             payload
//   s_*          in         s_valid / s_ready     in_beat_t (action, row, col, pixel_in)
//   m_*          out        m_valid / m_ready     out_beat_t (result_kind, pixel_out)
//   cfg_*        in         cfg_wr_en, no wait    cfg_index, cfg_data
//
// A read goes through the plane's registered read port. A run makes S sweeps, five reads per
// pixel through one read port, where S is passes = min(radius, rows + cols - 2) rounded up
// to even: an odd count ends with a copy sweep so the image returns to plane zero. Reset
// clears control state only; pixel storage is undefined until loaded. One item is worked
// on at a time; a finished result parks in a holding register while the output beat is
// stalled.
module manhattan_radius_max_filter_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int PIXEL_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mrmf_pkg::in_beat_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mrmf_pkg::out_beat_t         m_data,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [mrmf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import mrmf_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_MAX = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DIMW = $clog2(((DIM_MAX > 127) ? DIM_MAX : 127) + 1);
    localparam int EXTW = (PIXEL_BITS > FIELD_PIX_BITS) ? PIXEL_BITS : FIELD_PIX_BITS;

    top_state_t state_reg, state_next;
    logic [DIM_CFG_BITS-1:0]  rows_reg, cols_reg;
    logic [CFG_DATA_BITS-1:0] radius_reg;
    logic                     cur_sel_reg;
    logic                     in_area_reg;
    logic                     m_valid_reg;
    out_beat_t                m_data_reg;
    out_beat_t                pend_reg;

    logic [DIMW-1:0] num_rows, num_cols;
    logic [DIMW:0]   pass_limit;
    logic [7:0]      passes;
    logic            accept, in_area, out_free;
    logic            fin, top_rd_en, load_we, eng_start;
    out_beat_t       res;
    logic [AW-1:0]   pix_addr;
    logic [EXTW-1:0] pix_in_ext, pix_out_ext;
    logic [PIXEL_BITS-1:0] cur_rd_data;

    logic                  eng_rd_en, eng_wr_en;
    logic [AW-1:0]         eng_rd_addr, eng_wr_addr;
    logic [PIXEL_BITS-1:0] eng_wr_data;
    eng_status_t           eng_status;

    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [1:0]            ram_wr_en;
    logic [AW-1:0]         ram_wr_addr [2];
    logic [PIXEL_BITS-1:0] ram_wr_data [2];
    logic [PIXEL_BITS-1:0] ram_rd_data [2];

    always_comb begin
        if (rows_reg == '0) begin
            num_rows = DIMW'(1);
        end else if (DIMW'(rows_reg) > DIMW'(MAX_ROWS)) begin
            num_rows = DIMW'(MAX_ROWS);
        end else begin
            num_rows = DIMW'(rows_reg);
        end
        if (cols_reg == '0) begin
            num_cols = DIMW'(1);
        end else if (DIMW'(cols_reg) > DIMW'(MAX_COLS)) begin
            num_cols = DIMW'(MAX_COLS);
        end else begin
            num_cols = DIMW'(cols_reg);
        end
    end

    assign pass_limit = (DIMW+1)'(num_rows) + (DIMW+1)'(num_cols) - (DIMW+1)'(2);
    assign passes = ((DIMW+1)'(radius_reg) > pass_limit) ? pass_limit[7:0] : radius_reg;

    assign accept   = s_valid && s_ready;
    assign in_area  = (DIMW'(s_data.row) < num_rows) && (DIMW'(s_data.col) < num_cols);
    assign out_free = !m_valid_reg || m_ready;
    assign pix_addr = AW'(s_data.row) * AW'(MAX_COLS) + AW'(s_data.col);
    assign pix_in_ext = EXTW'(s_data.pixel_in);
    assign cur_rd_data = cur_sel_reg ? ram_rd_data[1] : ram_rd_data[0];
    assign pix_out_ext = EXTW'(cur_rd_data);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority if (s_data.action == ACT_LOAD) begin
                        state_next = out_free ? ST_IDLE : ST_HOLD;
                    end else if (s_data.action == ACT_RUN) begin
                        state_next = ST_RUN;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_RUN: begin
                if (eng_status.done) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        fin           = 1'b0;
        top_rd_en     = 1'b0;
        load_we       = 1'b0;
        eng_start     = 1'b0;
        res.result_kind = KIND_LOAD;
        res.pixel_out   = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    priority if (s_data.action == ACT_LOAD) begin
                        fin     = 1'b1;
                        load_we = in_area;
                    end else if (s_data.action == ACT_RUN) begin
                        eng_start = 1'b1;
                    end else begin
                        top_rd_en = 1'b1;
                    end
                end
            end
            ST_READ: begin
                fin             = 1'b1;
                res.result_kind = KIND_READ;
                res.pixel_out   = in_area_reg ? FIELD_PIX_BITS'(pix_out_ext) : '0;
            end
            ST_RUN: begin
                fin             = eng_status.done;
                res.result_kind = KIND_RUN;
            end
            ST_HOLD: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rows_reg    <= ROWS_RESET;
            cols_reg    <= COLS_RESET;
            radius_reg  <= RADIUS_RESET;
            cur_sel_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ROWS:   rows_reg   <= cfg_data[DIM_CFG_BITS-1:0];
                    CFG_COLS:   cols_reg   <= cfg_data[DIM_CFG_BITS-1:0];
                    CFG_RADIUS: radius_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (eng_status.pass_done) begin
                cur_sel_reg <= !cur_sel_reg;
            end
            if ((fin || state_reg == ST_HOLD) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_area_reg <= in_area;
        end
        if (fin && out_free) begin
            m_data_reg <= res;
        end else if (state_reg == ST_HOLD && out_free) begin
            m_data_reg <= pend_reg;
        end
        if (fin && !out_free) begin
            pend_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    mrmf_pass_engine #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (eng_start),
        .passes   (passes),
        .num_rows (num_rows),
        .num_cols (num_cols),
        .rd_en    (eng_rd_en),
        .rd_addr  (eng_rd_addr),
        .rd_data  (cur_rd_data),
        .wr_en    (eng_wr_en),
        .wr_addr  (eng_wr_addr),
        .wr_data  (eng_wr_data),
        .status   (eng_status)
    );

    assign ram_rd_en   = top_rd_en || eng_rd_en;
    assign ram_rd_addr = top_rd_en ? pix_addr : eng_rd_addr;

    for (genvar i = 0; i < 2; i++) begin : g_plane
        assign ram_wr_en[i] = (load_we && (cur_sel_reg == 1'(i)))
                           || (eng_wr_en && (cur_sel_reg != 1'(i)));
        assign ram_wr_addr[i] = load_we ? pix_addr : eng_wr_addr;
        assign ram_wr_data[i] = load_we ? pix_in_ext[PIXEL_BITS-1:0] : eng_wr_data;

        mrmf_ram #(
            .DEPTH (DEPTH),
            .WIDTH (PIXEL_BITS)
        ) u_plane (
            .aclk    (aclk),
            .wr_en   (ram_wr_en[i]),
            .wr_addr (ram_wr_addr[i]),
            .wr_data (ram_wr_data[i]),
            .rd_en   (ram_rd_en),
            .rd_addr (ram_rd_addr),
            .rd_data (ram_rd_data[i])
        );
    end

endmodule

// ===== rtl/core/mrmf_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Holds one image plane of the max filter; uses no package.
module mrmf_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mrmf_pass_engine.sv =====
// Pass sequencer of the max filter: sweeps the image once per pass, five reads per pixel.
// Reads the source plane, folds the maximum and writes the destination plane.
// Depends on mrmf_pkg.
module mrmf_pass_engine #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int PIXEL_BITS = 16,
    localparam int DEPTH = MAX_ROWS * MAX_COLS,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int DIM_MAX = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS,
    localparam int DIMW = $clog2(((DIM_MAX > 127) ? DIM_MAX : 127) + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [7:0]             passes,
    input  logic [DIMW-1:0]        num_rows,
    input  logic [DIMW-1:0]        num_cols,
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr,
    input  logic [PIXEL_BITS-1:0]  rd_data,
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output logic [PIXEL_BITS-1:0]  wr_data,
    output mrmf_pkg::eng_status_t  status
);
    import mrmf_pkg::*;

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_COLS);

    eng_state_t            state_reg, state_next;
    logic [8:0]            sweeps_left_reg;
    logic                  odd_reg;
    logic                  copy_reg;
    logic [RW-1:0]         r_cnt_reg;
    logic [CW-1:0]         c_cnt_reg;
    slot_t                 slot_reg;
    logic [AW-1:0]         center_reg;
    logic [AW-1:0]         row_base_reg;
    logic                  rd_valid_reg;
    slot_t                 rd_slot_reg;
    logic [AW-1:0]         rd_waddr_reg;
    logic [PIXEL_BITS-1:0] acc_reg;

    logic has_left, has_right, has_up, has_down;
    logic last_col, last_row;
    logic pixel_end, sweep_end;
    logic [PIXEL_BITS-1:0] fold;

    // An odd pass count ends with a copy sweep that reads only the center pixel, so the
    // filtered image always lands back in the plane that loads and reads use.
    assign last_col  = !((DIMW'(c_cnt_reg) + DIMW'(1)) < num_cols);
    assign last_row  = !((DIMW'(r_cnt_reg) + DIMW'(1)) < num_rows);
    assign has_left  = !copy_reg && (c_cnt_reg != '0);
    assign has_right = !copy_reg && !last_col;
    assign has_up    = !copy_reg && (r_cnt_reg != '0);
    assign has_down  = !copy_reg && !last_row;
    assign pixel_end = (slot_reg == SLOT_DOWN);
    assign sweep_end = pixel_end && last_col && last_row;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE: begin
                if (start) begin
                    state_next = (passes == 8'd0) ? ENG_FINISH : ENG_ISSUE;
                end
            end
            ENG_ISSUE: begin
                if (sweep_end) begin
                    state_next = ENG_DRAIN;
                end
            end
            ENG_DRAIN: begin
                state_next = (sweeps_left_reg == 9'd1) ? ENG_FINISH : ENG_ISSUE;
            end
            ENG_FINISH: begin
                state_next = ENG_IDLE;
            end
            default: begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_en            = 1'b0;
        status.pass_done = 1'b0;
        status.done      = 1'b0;
        unique case (state_reg)
            ENG_IDLE:   ;
            ENG_ISSUE:  rd_en = 1'b1;
            ENG_DRAIN:  status.pass_done = 1'b1;
            ENG_FINISH: status.done = 1'b1;
            default:    ;
        endcase
    end

    always_comb begin
        unique case (slot_reg)
            SLOT_CENTER: rd_addr = center_reg;
            SLOT_LEFT:   rd_addr = has_left  ? center_reg - AW'(1) : center_reg;
            SLOT_RIGHT:  rd_addr = has_right ? center_reg + AW'(1) : center_reg;
            SLOT_UP:     rd_addr = has_up    ? center_reg - ROW_STEP : center_reg;
            SLOT_DOWN:   rd_addr = has_down  ? center_reg + ROW_STEP : center_reg;
            default:     rd_addr = center_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ENG_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ENG_ISSUE);
        end
    end

    always_ff @(posedge aclk) begin
        rd_slot_reg  <= slot_reg;
        rd_waddr_reg <= center_reg;
        unique case (state_reg)
            ENG_IDLE: begin
                sweeps_left_reg <= {1'b0, passes} + {8'd0, passes[0]};
                odd_reg         <= passes[0];
                copy_reg        <= 1'b0;
                r_cnt_reg       <= '0;
                c_cnt_reg       <= '0;
                slot_reg        <= SLOT_CENTER;
                center_reg      <= '0;
                row_base_reg    <= '0;
            end
            ENG_ISSUE: begin
                if (pixel_end) begin
                    slot_reg <= SLOT_CENTER;
                    if (last_col) begin
                        c_cnt_reg    <= '0;
                        r_cnt_reg    <= r_cnt_reg + RW'(1);
                        row_base_reg <= row_base_reg + ROW_STEP;
                        center_reg   <= row_base_reg + ROW_STEP;
                    end else begin
                        c_cnt_reg  <= c_cnt_reg + CW'(1);
                        center_reg <= center_reg + AW'(1);
                    end
                end else begin
                    slot_reg <= slot_t'(slot_reg + 3'd1);
                end
            end
            ENG_DRAIN: begin
                sweeps_left_reg <= sweeps_left_reg - 9'd1;
                copy_reg        <= odd_reg && (sweeps_left_reg == 9'd2);
                r_cnt_reg       <= '0;
                c_cnt_reg       <= '0;
                slot_reg        <= SLOT_CENTER;
                center_reg      <= '0;
                row_base_reg    <= '0;
            end
            ENG_FINISH: ;
            default: ;
        endcase
    end

    assign fold = (rd_slot_reg == SLOT_CENTER || rd_data > acc_reg) ? rd_data : acc_reg;

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            acc_reg <= fold;
        end
    end

    assign wr_en   = rd_valid_reg && (rd_slot_reg == SLOT_DOWN);
    assign wr_addr = rd_waddr_reg;
    assign wr_data = fold;

endmodule
